[src/leh_pkg.sv]
// Shared constants and types of the line editor with history.
package leh_pkg;

   localparam int HIST_LINES = 16;
   localparam int LINE_LEN   = 64;
   localparam int HIST_W     = $clog2(HIST_LINES);
   localparam int COL_W      = $clog2(LINE_LEN) > 0 ? $clog2(LINE_LEN) : 1;
   localparam int ADDR_W     = HIST_W + COL_W;
   localparam int MEM_DEPTH  = HIST_LINES * LINE_LEN;
   localparam int POS_W      = 7;
   localparam int CHAR_W     = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W     = 1;

   localparam logic [CHAR_W-1:0] KEY_SPACE = 8'h20;

   typedef enum logic [2:0] {
      KIND_INSERT = 3'd0,
      KIND_BACKSPACE = 3'd1,
      KIND_DELETE = 3'd2,
      KIND_LEFT = 3'd3,
      KIND_RIGHT = 3'd4,
      KIND_UP = 3'd5,
      KIND_DOWN = 3'd6,
      KIND_ENTER = 3'd7
   } kind_type;

   // One classified event between front and back.
   typedef struct packed {
      kind_type          kind;
      logic [CHAR_W-1:0] key_char;
      logic              null_char;
      logic              space_char;
   } event_type;

endpackage

[src/leh_ram.sv]
// Generic RAM with one write port, one read port and registered read.
module leh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one word, read one word a cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

[src/leh_front.sv]
// Front end: accepts key events, classifies them and queues them.
module leh_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_kind,
   input  logic [7:0]          req_key_char,
   output logic                ev_valid,
   output leh_pkg::event_type  ev_data,
   input  logic                ev_take
);
   import leh_pkg::*;

   event_type           q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;
   logic                push;
   event_type           ev_new;

   // Classify the incoming event.
   always_comb begin
      ev_new.kind       = kind_type'(req_kind);
      ev_new.key_char   = req_key_char;
      ev_new.null_char  = (req_key_char == '0);
      ev_new.space_char = (req_key_char == KEY_SPACE);
   end

   assign busy     = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH)) ? 1'b1 : 1'b0;
   assign push     = start && !busy;
   assign ev_valid = (cnt_ff != '0);
   assign ev_data  = q_ff[rd_ff];

   // Advance queue pointers.
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = ev_take ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(ev_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= ev_new;
      end
   end
endmodule

[src/leh_back.sv]
// Back end: carries out editing, history copy and line output.
module leh_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                ev_valid,
   input  leh_pkg::event_type  ev_data,
   output logic                ev_take,
   output logic                rsp_strobe,
   output logic                rsp_status,
   output logic [6:0]          rsp_cursor_pos,
   output logic [6:0]          rsp_line_length,
   output logic [7:0]          rsp_line_char,
   output logic                rsp_char_valid,
   output logic                rsp_last
);
   import leh_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SHIFT_RD, ST_SHIFT_WR, ST_COPY_RD, ST_COPY_WR, ST_OUT_RD, ST_OUT_WR
   } state_type;

   state_type           state_ff;
   logic [POS_W-1:0]    lens_ff [HIST_LINES];
   logic [HIST_W-1:0]   oldest_ff, newest_ff, browse_ff, src_ff;
   logic [POS_W-1:0]    cursor_ff, len_ff, idx_ff, end_ff;
   logic                dir_ff;
   logic [CHAR_W-1:0]   char_ff;
   kind_type            kind_ff;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   logic [CHAR_W-1:0]   wr_data, rd_data;
   logic [POS_W-1:0]    cur_len, cur_cur;
   logic [HIST_W-1:0]   br_up, br_dn;

   leh_ram #(.WIDTH(CHAR_W), .DEPTH(MEM_DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // Clamp current line state as the model does on each step.
   always_comb begin
      cur_len = (lens_ff[newest_ff] > POS_W'(LINE_LEN)) ? POS_W'(LINE_LEN)
                                                        : lens_ff[newest_ff];
      cur_cur = (cursor_ff > cur_len) ? cur_len : cursor_ff;
      br_up   = browse_ff - 1'b1;
      br_dn   = browse_ff + 1'b1;
   end

   assign ev_take = (state_ff == ST_IDLE) && ev_valid;

   // Drive memory ports from the walking index.
   always_comb begin
      wr_en   = 1'b0;
      wr_data = rd_data;
      wr_addr = {newest_ff, idx_ff[COL_W-1:0]};
      rd_addr = {newest_ff, idx_ff[COL_W-1:0]};
      unique case (state_ff)
         ST_SHIFT_RD: begin
            // dir 1: shift right, read idx-1; dir 0: shift left, read idx+1
            rd_addr = {newest_ff, dir_ff ? COL_W'(idx_ff - 1'b1)
                                         : COL_W'(idx_ff + 1'b1)};
         end
         ST_SHIFT_WR: begin
            wr_en = 1'b1;
         end
         ST_COPY_RD: begin
            rd_addr = {src_ff, idx_ff[COL_W-1:0]};
         end
         ST_COPY_WR: begin
            wr_en = 1'b1;
         end
         ST_OUT_RD: begin
            // The entered line is the previous ring entry.
            rd_addr = {src_ff, idx_ff[COL_W-1:0]};
         end
         ST_IDLE: begin
            // Place inserted char after the shift completes.
            wr_en   = (kind_ff == KIND_INSERT) && dir_ff;
            wr_data = char_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_strobe <= 1'b0;
      if (reset) begin
         state_ff  <= ST_IDLE;
         oldest_ff <= '0;
         newest_ff <= '0;
         browse_ff <= '0;
         cursor_ff <= '0;
         dir_ff    <= 1'b0;
         kind_ff   <= KIND_LEFT;
         for (int i = 0; i < HIST_LINES; i++) lens_ff[i] <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               dir_ff  <= 1'b0;
               kind_ff <= KIND_LEFT;
               if (ev_take) begin
                  cursor_ff       <= cur_cur;
                  rsp_status      <= 1'b0;
                  rsp_line_char   <= '0;
                  rsp_char_valid  <= 1'b0;
                  rsp_last        <= 1'b1;
                  rsp_cursor_pos  <= cur_cur;
                  rsp_line_length <= cur_len;
                  unique case (ev_data.kind)
                     KIND_INSERT: begin
                        if (cur_len >= POS_W'(LINE_LEN) || ev_data.null_char ||
                            (cur_len == '0 && ev_data.space_char)) begin
                           rsp_status <= 1'b1;
                           rsp_strobe <= 1'b1;
                        end else begin
                           char_ff <= ev_data.key_char;
                           idx_ff  <= cur_len;
                           end_ff  <= cur_cur;
                           len_ff  <= cur_len + 1'b1;
                           dir_ff  <= 1'b1;
                           kind_ff <= KIND_INSERT;
                           state_ff <= (cur_len > cur_cur) ? ST_SHIFT_RD : ST_IDLE;
                           if (cur_len == cur_cur) begin
                              idx_ff <= cur_cur;
                              lens_ff[newest_ff] <= cur_len + 1'b1;
                              cursor_ff <= cur_cur + 1'b1;
                              rsp_cursor_pos <= cur_cur + 1'b1;
                              rsp_line_length <= cur_len + 1'b1;
                              rsp_strobe <= 1'b1;
                           end
                        end
                     end
                     KIND_BACKSPACE, KIND_DELETE: begin
                        if (cur_len == '0 ||
                            (ev_data.kind == KIND_BACKSPACE && cur_cur == '0) ||
                            (ev_data.kind == KIND_DELETE && cur_cur >= cur_len)) begin
                           rsp_status <= 1'b1;
                           rsp_strobe <= 1'b1;
                        end else begin
                           logic [POS_W-1:0] st;
                           st = (ev_data.kind == KIND_BACKSPACE) ? cur_cur - 1'b1
                                                                 : cur_cur;
                           cursor_ff <= st;
                           lens_ff[newest_ff] <= cur_len - 1'b1;
                           len_ff   <= cur_len - 1'b1;
                           idx_ff   <= st;
                           rsp_cursor_pos  <= st;
                           rsp_line_length <= cur_len - 1'b1;
                           if (st + 1'b1 < cur_len) begin
                              state_ff <= ST_SHIFT_RD;
                           end else begin
                              rsp_strobe <= 1'b1;
                           end
                        end
                     end
                     KIND_LEFT: begin
                        if (cur_cur == '0) rsp_status <= 1'b1;
                        else begin
                           cursor_ff <= cur_cur - 1'b1;
                           rsp_cursor_pos <= cur_cur - 1'b1;
                        end
                        rsp_strobe <= 1'b1;
                     end
                     KIND_RIGHT: begin
                        if (cur_cur >= cur_len) rsp_status <= 1'b1;
                        else begin
                           cursor_ff <= cur_cur + 1'b1;
                           rsp_cursor_pos <= cur_cur + 1'b1;
                        end
                        rsp_strobe <= 1'b1;
                     end
                     KIND_UP, KIND_DOWN: begin
                        logic [HIST_W-1:0] nb;
                        logic [POS_W-1:0]  sl;
                        nb = (ev_data.kind == KIND_UP) ? br_up : br_dn;
                        sl = (lens_ff[nb] > POS_W'(LINE_LEN)) ? POS_W'(LINE_LEN)
                                                              : lens_ff[nb];
                        if ((ev_data.kind == KIND_UP && browse_ff == oldest_ff) ||
                            (ev_data.kind == KIND_DOWN && browse_ff == newest_ff)) begin
                           rsp_status <= 1'b1;
                           rsp_strobe <= 1'b1;
                        end else begin
                           browse_ff <= nb;
                           if (nb == newest_ff) begin
                              cursor_ff <= cur_len;
                              lens_ff[newest_ff] <= cur_len;
                              rsp_cursor_pos <= cur_len;
                              rsp_strobe <= 1'b1;
                           end else begin
                              lens_ff[newest_ff] <= sl;
                              cursor_ff <= sl;
                              rsp_cursor_pos  <= sl;
                              rsp_line_length <= sl;
                              src_ff <= nb;
                              len_ff <= sl;
                              idx_ff <= '0;
                              if (sl == '0) rsp_strobe <= 1'b1;
                              else state_ff <= ST_COPY_RD;
                           end
                        end
                     end
                     default: begin
                        // Enter: advance ring, then stream the old line.
                        logic [HIST_W-1:0] nn;
                        nn = newest_ff + 1'b1;
                        lens_ff[newest_ff] <= cur_len;
                        lens_ff[nn] <= '0;
                        newest_ff <= nn;
                        browse_ff <= nn;
                        src_ff    <= newest_ff;
                        if (nn == oldest_ff) oldest_ff <= oldest_ff + 1'b1;
                        cursor_ff <= '0;
                        rsp_cursor_pos  <= '0;
                        rsp_line_length <= '0;
                        len_ff <= cur_len;
                        idx_ff <= '0;
                        if (cur_len == '0) rsp_strobe <= 1'b1;
                        else state_ff <= ST_OUT_RD;
                     end
                  endcase
               end
            end
            ST_SHIFT_RD: state_ff <= ST_SHIFT_WR;
            ST_SHIFT_WR: begin
               if (dir_ff) begin
                  // Insert: walk down from len to cursor+1.
                  if (idx_ff - 1'b1 == end_ff) begin
                     idx_ff <= end_ff;
                     lens_ff[newest_ff] <= len_ff;
                     cursor_ff <= end_ff + 1'b1;
                     rsp_cursor_pos  <= end_ff + 1'b1;
                     rsp_line_length <= len_ff;
                     rsp_strobe <= 1'b1;
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff <= idx_ff - 1'b1;
                     state_ff <= ST_SHIFT_RD;
                  end
               end else begin
                  if (idx_ff + 1'b1 >= len_ff) begin
                     rsp_strobe <= 1'b1;
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                     state_ff <= ST_SHIFT_RD;
                  end
               end
            end
            ST_COPY_RD: state_ff <= ST_COPY_WR;
            ST_COPY_WR: begin
               if (idx_ff + 1'b1 >= len_ff) begin
                  rsp_strobe <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= ST_COPY_RD;
               end
            end
            ST_OUT_RD: state_ff <= ST_OUT_WR;
            ST_OUT_WR: begin
               rsp_strobe     <= 1'b1;
               rsp_status     <= 1'b0;
               rsp_line_char  <= rd_data;
               rsp_char_valid <= 1'b1;
               rsp_last       <= (idx_ff + 1'b1 == len_ff);
               if (idx_ff + 1'b1 == len_ff) begin
                  state_ff <= ST_IDLE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= ST_OUT_RD;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

[src/line_editor_with_history.sv]
// Top level of the line editor with history ring.
//
// Key events enter on req_kind/req_key_char when start is high and busy
// is low. A front queue of two beats takes events while the back end
// works. Results leave as one-cycle beats marked by rsp_strobe; the
// receiver cannot stall them.
// Every event but a nonempty enter gives one beat. Cursor moves and
// rejected events answer with a beat registered when the event is taken.
// Insert and delete walk the line tail through the character RAM, a
// read state and a write state per moved character; history up/down
// copies a line the same way; enter emits one character beat per read
// and write state. The back end takes no new event until it is idle.
// Reset empties the queue and all line lengths and ring pointers; the
// character RAM needs no clearing since only written characters are
// ever read.
module line_editor_with_history (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_kind,
   input  logic [7:0] req_key_char,
   output logic       rsp_strobe,
   output logic       rsp_status,
   output logic [6:0] rsp_cursor_pos,
   output logic [6:0] rsp_line_length,
   output logic [7:0] rsp_line_char,
   output logic       rsp_char_valid,
   output logic       rsp_last
);
   import leh_pkg::*;

   logic      ev_valid, ev_take;
   event_type ev_data;

   leh_front u_front (
      .clock, .reset, .start, .busy, .req_kind, .req_key_char,
      .ev_valid, .ev_data, .ev_take
   );

   leh_back u_back (
      .clock, .reset, .ev_valid, .ev_data, .ev_take,
      .rsp_strobe, .rsp_status, .rsp_cursor_pos, .rsp_line_length,
      .rsp_line_char, .rsp_char_valid, .rsp_last
   );
endmodule

[tb/sv/tb.sv]
// Testbench for the line editor with history ring: queued key events, predicted beats.
`timescale 1ns / 1ps

module tb;
   import leh_pkg::*;

   // one key event waiting to be sent; hold_off makes the sender drain first
   typedef struct {
      kind_type   kind;
      logic [7:0] key_char;
      bit         hold_off;
   } key_event_type;

   // one predicted response beat
   typedef struct {
      logic       status;
      logic [6:0] cursor_pos;
      logic [6:0] line_length;
      logic [7:0] line_char;
      logic       char_valid;
      logic       last;
   } beat_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [2:0] req_kind;
   logic [7:0] req_key_char;
   logic       rsp_strobe;
   logic       rsp_status;
   logic [6:0] rsp_cursor_pos;
   logic [6:0] rsp_line_length;
   logic [7:0] rsp_line_char;
   logic       rsp_char_valid;
   logic       rsp_last;

   key_event_type pending_keys[$];
   beat_type      expected_beats[$];
   int            mismatches;
   int            cycle_count;
   int            send_gap;

   // editor shadow state
   logic [7:0]        shadow_chars[HIST_LINES][LINE_LEN];
   logic [6:0]        shadow_lens[HIST_LINES];
   logic [HIST_W-1:0] shadow_oldest, shadow_newest, shadow_browse;
   logic [6:0]        shadow_cursor;

   line_editor_with_history uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_key_char(req_key_char),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_cursor_pos(rsp_cursor_pos), .rsp_line_length(rsp_line_length),
      .rsp_line_char(rsp_line_char), .rsp_char_valid(rsp_char_valid),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // copy a browsed line into the working line
   task automatic copy_to_working(input logic [HIST_W-1:0] src);
      if (src != shadow_newest)
         for (int i = 0; i < shadow_lens[src]; i++)
            shadow_chars[shadow_newest][i] = shadow_chars[src][i];
      shadow_lens[shadow_newest] = shadow_lens[src];
   endtask

   // apply one key event to the shadow editor and queue its beats
   task automatic edit_and_predict(input key_event_type ev);
      beat_type          b;
      logic [HIST_W-1:0] wl;
      int                len;
      bit                rej;
      wl  = shadow_newest;
      len = shadow_lens[wl];
      rej = 0;
      if (shadow_cursor > len) shadow_cursor = len;
      b = '{1'b0, 7'd0, 7'd0, 8'd0, 1'b0, 1'b1};
      case (ev.kind)
         KIND_INSERT: begin
            if (len >= LINE_LEN || ev.key_char == 8'd0 || (len == 0 && ev.key_char == KEY_SPACE))
               rej = 1;
            else begin
               for (int i = len; i > shadow_cursor; i--)
                  shadow_chars[wl][i] = shadow_chars[wl][i-1];
               shadow_chars[wl][shadow_cursor] = ev.key_char;
               shadow_cursor++;
               len++;
            end
         end
         KIND_BACKSPACE: begin
            if (len == 0 || shadow_cursor == 0) rej = 1;
            else begin
               for (int i = shadow_cursor; i < len; i++)
                  shadow_chars[wl][i-1] = shadow_chars[wl][i];
               len--;
               shadow_cursor--;
            end
         end
         KIND_DELETE: begin
            if (len == 0 || shadow_cursor >= len) rej = 1;
            else begin
               for (int i = shadow_cursor + 1; i < len; i++)
                  shadow_chars[wl][i-1] = shadow_chars[wl][i];
               len--;
            end
         end
         KIND_LEFT: begin
            if (shadow_cursor == 0) rej = 1;
            else shadow_cursor--;
         end
         KIND_RIGHT: begin
            if (shadow_cursor >= len) rej = 1;
            else shadow_cursor++;
         end
         KIND_UP: begin
            if (shadow_browse == shadow_oldest) rej = 1;
            else begin
               shadow_browse = shadow_browse - 1'b1;
               copy_to_working(shadow_browse);
               len = shadow_lens[wl];
               shadow_cursor = len;
            end
         end
         KIND_DOWN: begin
            if (shadow_browse == shadow_newest) rej = 1;
            else begin
               shadow_browse = shadow_browse + 1'b1;
               if (shadow_browse != shadow_newest) copy_to_working(shadow_browse);
               len = shadow_lens[wl];
               shadow_cursor = len;
            end
         end
         default: begin
            // advance the ring, then emit the old line
            shadow_newest = shadow_newest + 1'b1;
            if (shadow_newest == shadow_oldest) shadow_oldest = shadow_oldest + 1'b1;
            shadow_lens[shadow_newest] = 7'd0;
            shadow_cursor = 7'd0;
            shadow_browse = shadow_newest;
            if (len == 0) expected_beats.push_back(b);
            for (int i = 0; i < len; i++) begin
               b.line_char  = shadow_chars[wl][i];
               b.char_valid = 1'b1;
               b.last       = (i + 1 == len);
               expected_beats.push_back(b);
            end
            return;
         end
      endcase
      shadow_lens[wl] = len[6:0];
      b.status      = rej;
      b.cursor_pos  = shadow_cursor;
      b.line_length = len[6:0];
      expected_beats.push_back(b);
   endtask

   task automatic add_key(input kind_type k, input logic [7:0] c, input bit hold = 0);
      key_event_type ev;
      ev.kind     = k;
      ev.key_char = c;
      ev.hold_off = hold;
      pending_keys.push_back(ev);
   endtask

   function automatic logic [7:0] word_char();
      return (8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(33, 126)));
   endfunction

   // sender: present queued events, random gaps between them
   always @(posedge clock) begin
      key_event_type ev;
      logic          next_start;
      if (reset) begin
         start    <= 1'b0;
         send_gap = 0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            edit_and_predict('{kind_type'(req_kind), req_key_char, 1'b0});
            next_start = 1'b0;
            send_gap   = $urandom_range(0, 6);
         end
         if (!next_start) begin
            if (send_gap > 0) send_gap--;
            else if (pending_keys.size() > 0 &&
                     (!pending_keys[0].hold_off || expected_beats.size() == 0)) begin
               ev = pending_keys.pop_front();
               req_kind     <= ev.kind;
               req_key_char <= ev.key_char;
               next_start   = 1'b1;
            end
         end
         start <= next_start;
      end
   end

   // receiver: check every strobed beat against the oldest prediction
   always @(posedge clock) begin
      beat_type e;
      if (!reset && rsp_strobe) begin
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat at cycle %0d", cycle_count);
         end else begin
            e = expected_beats.pop_front();
            if (rsp_status !== e.status || rsp_cursor_pos !== e.cursor_pos ||
                rsp_line_length !== e.line_length || rsp_line_char !== e.line_char ||
                rsp_char_valid !== e.char_valid || rsp_last !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch cycle %0d: exp st%0d cur%0d len%0d ch%h v%0d l%0d,",
                           cycle_count, e.status, e.cursor_pos, e.line_length,
                           e.line_char, e.char_valid, e.last,
                           " got st%0d cur%0d len%0d ch%h v%0d l%0d", rsp_status,
                           rsp_cursor_pos, rsp_line_length, rsp_line_char,
                           rsp_char_valid, rsp_last);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 300000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      mismatches    = 0;
      cycle_count   = 0;
      reset         = 1'b1;
      start         = 1'b0;
      req_kind      = 3'd0;
      req_key_char  = 8'd0;
      shadow_oldest = '0;
      shadow_newest = '0;
      shadow_browse = '0;
      shadow_cursor = '0;
      for (int i = 0; i < HIST_LINES; i++) begin
         shadow_lens[i] = '0;
         for (int j = 0; j < LINE_LEN; j++) shadow_chars[i][j] = '0;
      end

      // directed: rejections on an empty editor, edits, enter, browsing
      add_key(KIND_UP, 8'hFF);
      add_key(KIND_DOWN, 8'h00);
      add_key(KIND_BACKSPACE, 8'h41);
      add_key(KIND_DELETE, 8'h41);
      add_key(KIND_LEFT, 8'h41);
      add_key(KIND_RIGHT, 8'h41);
      add_key(KIND_INSERT, KEY_SPACE);
      add_key(KIND_INSERT, 8'h00);
      add_key(KIND_ENTER, 8'h00);
      add_key(KIND_INSERT, 8'h01);
      add_key(KIND_INSERT, 8'hFF);
      add_key(KIND_INSERT, KEY_SPACE);
      add_key(KIND_LEFT, 8'h00);
      add_key(KIND_INSERT, 8'h7A);
      add_key(KIND_RIGHT, 8'h00);
      add_key(KIND_DELETE, 8'h00);
      add_key(KIND_LEFT, 8'h00);
      add_key(KIND_DELETE, 8'h00);
      add_key(KIND_BACKSPACE, 8'h00);
      add_key(KIND_ENTER, 8'h00);
      add_key(KIND_UP, 8'h00);
      add_key(KIND_UP, 8'h00);
      add_key(KIND_UP, 8'h00);
      add_key(KIND_DOWN, 8'h00);
      add_key(KIND_DOWN, 8'h00, 1);

      // random: mostly typed lines with edits and browsing, some noise
      while (pending_keys.size() < 140) begin
         case ($urandom_range(0, 9))
            0: begin
               add_key(kind_type'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            end
            1: begin
               // fill to the full line; at least the last insert is refused
               for (int i = 0; i < LINE_LEN + 1; i++) add_key(KIND_INSERT, word_char() | 8'h40);
               add_key(KIND_ENTER, 8'($urandom_range(0, 255)), $urandom_range(0, 1));
            end
            2, 3: begin
               repeat ($urandom_range(1, 4))
                  add_key($urandom_range(0, 1) ? KIND_UP : KIND_DOWN, 8'($urandom_range(0, 255)));
               if ($urandom_range(0, 1)) add_key(KIND_INSERT, word_char());
               add_key(KIND_ENTER, 8'($urandom_range(0, 255)));
            end
            default: begin
               repeat ($urandom_range(1, 10)) begin
                  case ($urandom_range(0, 7))
                     0: add_key(KIND_LEFT, 8'($urandom_range(0, 255)));
                     1: add_key(KIND_RIGHT, 8'($urandom_range(0, 255)));
                     2: add_key(KIND_BACKSPACE, 8'($urandom_range(0, 255)));
                     3: add_key(KIND_DELETE, 8'($urandom_range(0, 255)));
                     default: add_key(KIND_INSERT, word_char());
                  endcase
               end
               add_key(KIND_ENTER, 8'($urandom_range(0, 255)));
            end
         endcase
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // drain: all sent, all beats in, then a latency margin
      wait (pending_keys.size() == 0 && !start && expected_beats.size() == 0);
      repeat (300) @(posedge clock);
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
